>>> design/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

  // Longest pattern the window can hold.
  localparam int PATTERN_MAX = 32;
  localparam int LEN_CAP     = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
  localparam int WIN_BYTES   = LEN_CAP;
  localparam int IDX_W       = $clog2(WIN_BYTES);
  localparam int LEN_W       = 6;
  localparam int PAT_BYTES   = 32;
  localparam int CNT_W       = 32;
  localparam int ADDR_W      = 64;
  localparam int OFS_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_B  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_C  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 4'd7;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;
  typedef logic [PAT_BYTES-1:0][7:0] pat_t;

  // What the comparator needs to know about the pattern.
  typedef struct packed {
    pat_t                 pattern;
    logic [PAT_BYTES-1:0] wild;
    logic [LEN_W-1:0]     len;     // already clamped to 1..LEN_CAP
  } match_cfg_t;

endpackage

`default_nettype wire

>>> design/wbps_ifs.sv
`default_nettype none

interface wbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] address;

  modport source (output valid, output found, output address, input ready);
  modport sink   (input valid, input found, input address, output ready);
endinterface

`default_nettype wire

>>> design/wildcard_byte_pattern_scanner.sv
`default_nettype none

// Channel   Dir  Payload                     Transaction when
// in_chan   in   data_byte[7:0], last_byte   valid & ready
// out_chan  out  found, address[63:0]        valid & ready
// cfg_*     in   cfg_index[3:0], cfg_data    cfg_we high
//
// One byte per cycle sustained while the result is not stalled; the path
// from input transaction to result is the input/window register, then
// compare + 64-bit add into the result register. A region yields exactly one
// result: found at the first match, or not-found on the last byte.
// Synchronous active-low reset clears control state; no clearing pass.
// A stalled result holds the pipe only when a byte is waiting behind it.
module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wbps_byte_if.sink                  in_chan,
  wbps_res_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  pat_t                 pat_r;
  logic [PAT_BYTES-1:0] mask_r;
  logic [LEN_W-1:0]     len_r;
  logic [OFS_W-1:0]     offset_r;
  logic [ADDR_W-1:0]    base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      mask_r   <= '0;
      len_r    <= LEN_W'(1);
      offset_r <= '0;
      base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LO: pat_r[7:0]   <= cfg_data;
        REG_PAT_B:  pat_r[15:8]  <= cfg_data;
        REG_PAT_C:  pat_r[23:16] <= cfg_data;
        REG_PAT_HI: pat_r[31:24] <= cfg_data;
        REG_MASK:   mask_r       <= cfg_data[PAT_BYTES-1:0];
        REG_LEN:    len_r        <= cfg_data[LEN_W-1:0];
        REG_OFFSET: offset_r     <= cfg_data[OFS_W-1:0];
        REG_BASE:   base_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // length 0 behaves as 1, anything beyond the window is clamped
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = len_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: window shift register and byte count
  // ---------------------------------------------------------------
  logic             s1_valid_r;
  logic             s1_last_r;   // also marks "next byte starts a region"
  logic             s1_full_r;   // enough bytes seen for a whole pattern
  logic [CNT_W-1:0] s1_start_r;  // match start offset if full
  logic [CNT_W-1:0] seen_r;
  win_t             win_r;

  logic             adv;
  logic             in_acc;
  logic [CNT_W-1:0] seen_nxt;
  logic [CNT_W:0]   diff;

  assign adv            = s1_valid_r && (!out_chan.valid || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || adv;
  assign in_acc         = in_chan.valid && in_chan.ready;

  // count restarts after a last byte, otherwise saturates
  always_comb begin
    if (s1_last_r) begin
      seen_nxt = CNT_W'(1);
    end else if (&seen_r) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + CNT_W'(1);
    end
    diff = {1'b0, seen_nxt} - {{(CNT_W + 1 - LEN_W){1'b0}}, len_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      seen_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_last_r  <= in_chan.last_byte;
        seen_r     <= seen_nxt;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stale window bytes past the count are never compared
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r      <= {win_r[WIN_BYTES-2:0], in_chan.data_byte};
      s1_full_r  <= !diff[CNT_W];
      s1_start_r <= diff[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: compare, address sum, result register
  // ---------------------------------------------------------------
  match_cfg_t mcfg;
  logic       win_hit;

  assign mcfg.pattern = pat_r;
  assign mcfg.wild    = mask_r;
  assign mcfg.len     = len_eff;

  wbps_match u_match (
    .cfg    (mcfg),
    .window (win_r),
    .hit    (win_hit)
  );

  logic              match_reported_r;
  logic              hit;
  logic              emit;
  logic [ADDR_W-1:0] addr_sum;

  assign hit      = s1_full_r && !match_reported_r && win_hit;
  assign emit     = hit || (s1_last_r && !match_reported_r);
  assign addr_sum = base_r + {{(ADDR_W - CNT_W){1'b0}}, s1_start_r}
                  + {{(ADDR_W - OFS_W){1'b0}}, offset_r};

  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_reported_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (adv) begin
        match_reported_r <= s1_last_r ? 1'b0 : (match_reported_r || hit);
        out_valid_r      <= emit;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? addr_sum : '0;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.found   = out_found_r;
  assign out_chan.address = out_addr_r;

`ifndef SYNTHESIS
  a_seen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> seen_r != '0)
    else $error("byte in window stage with zero count");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_addr_r == '0)
    else $error("not-found result with non-zero address");

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> !match_reported_r)
    else $error("match flag survived end of region");

  a_hit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    adv && hit && !s1_last_r |=> match_reported_r)
    else $error("match not recorded");

  a_one_per_region: assert property (@(posedge clk) disable iff (!rst_n)
    adv && match_reported_r |-> !emit)
    else $error("second result in one region");
`endif

endmodule

`default_nettype wire

>>> design/wbps_match.sv
`default_nettype none

// Parallel compare of the byte window against the pattern, one lane per
// pattern byte. Lane i looks at window entry len-1-i (entry 0 is newest).
module wbps_match
  import wbps_pkg::*;
(
  input  var match_cfg_t cfg,
  input  var win_t       window,
  output logic           hit
);

  logic [WIN_BYTES-1:0] lane_ok;

  always_comb begin : p_lanes
    logic [LEN_W-1:0] sel;
    sel = '0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      sel = cfg.len - LEN_W'(i + 1);
      if (LEN_W'(i) >= cfg.len || cfg.wild[i]) begin
        lane_ok[i] = 1'b1;
      end else begin
        lane_ok[i] = (window[sel[IDX_W-1:0]] == cfg.pattern[i]);
      end
    end
  end

  assign hit = &lane_ok;

endmodule

`default_nettype wire
